>>> rtl/lcps_pkg.sv
// Shared types and constants for the line-center PI steering core.
// Used by every module under rtl/; depends on nothing else.
`timescale 1ns / 1ps

package lcps_pkg;

  localparam int POS_W      = 10;
  localparam int ERR_W      = 11;
  localparam int INTEG_W    = 40;
  localparam int NUM_W      = 51;
  localparam int QUO_W      = 37;
  localparam int SPLIT      = 19;
  localparam int REM_W      = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int QUEUE_DEPTH = 4;

  // Divide by 10000 in 16-bit digits: each partial dividend is shifted right by
  // four and multiplied by a reciprocal of 625 that is exact below 2^26.
  localparam int DIV_W       = 64;
  localparam int DIG_W       = 16;
  localparam int DIGITS      = DIV_W / DIG_W;
  localparam int PART_W      = REM_W + DIG_W;
  localparam int RECIP_W     = 27;
  localparam int RECIP_SHIFT = 36;
  localparam logic [RECIP_W-1:0] RECIP_625 = 27'd109951163;

  localparam logic [POS_W-1:0] POS_MAX    = {POS_W{1'b1}};
  localparam logic [REM_W:0]   DIVISOR    = 15'd10000;
  localparam logic [7:0]       PROP_SCALE = 8'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_KP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KI     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CRUISE = 3'd5;

  typedef struct packed {
    logic [9:0]  prop_gain_hundredths;
    logic [9:0]  integ_gain_ten_thousandths;
    logic [15:0] time_step;
    logic [15:0] angular_scale;
    logic [7:0]  lost_limit;
    logic [15:0] cruise_speed;
  } cfg_t;

  typedef struct packed {
    logic             seen;
    logic [POS_W-1:0] first_edge;
    logic [POS_W-1:0] last_edge;
  } row_sum_t;

  typedef struct packed {
    logic        stopped;
    logic        line_seen;
    logic [9:0]  pixel_error;
    logic [15:0] forward_rate;
    logic [31:0] angular_rate;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ERR, ST_INTEG, ST_ACC, ST_PROP, ST_PSCALE, ST_ILO,
    ST_IHI, ST_DIVSET, ST_DQ, ST_DR, ST_SLO, ST_SHI, ST_SAT, ST_OUT
  } back_state_t;

endpackage

>>> rtl/lcps_front.sv
// Pixel front end: counts pixels in a scan row and tracks the first and last edge.
// Pushes one row summary per row end into the row queue. Depends on lcps_pkg.
`timescale 1ns / 1ps

module lcps_front #(
  parameter int unsigned ROW_WIDTH = 500
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              edge_bit,
  input  logic              row_end,
  input  logic              full,
  output logic              push,
  output lcps_pkg::row_sum_t push_data
);
  import lcps_pkg::*;

  localparam logic [POS_W-1:0] ROW_LIM = POS_W'(ROW_WIDTH);

  logic [POS_W-1:0] pixel_position;
  logic [POS_W-1:0] first_edge;
  logic [POS_W-1:0] last_edge;
  logic             edge_found;

  logic             take;
  logic             hit;
  logic [POS_W-1:0] first_next;
  logic [POS_W-1:0] last_next;
  logic             found_next;

  assign in_ready = !full;
  assign take     = in_valid && in_ready;

  // Edges beyond the row width do not count.
  assign hit        = edge_bit && (pixel_position < ROW_LIM);
  assign first_next = (hit && !edge_found) ? pixel_position : first_edge;
  assign last_next  = hit ? pixel_position : last_edge;
  assign found_next = edge_found || hit;

  assign push      = take && row_end;
  assign push_data = '{seen: found_next, first_edge: first_next, last_edge: last_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_position <= '0;
      first_edge     <= '0;
      last_edge      <= '0;
      edge_found     <= 1'b0;
    end else if (take) begin
      if (row_end) begin
        pixel_position <= '0;
        first_edge     <= '0;
        last_edge      <= '0;
        edge_found     <= 1'b0;
      end else begin
        if (pixel_position != POS_MAX) begin
          pixel_position <= pixel_position + 1'b1;
        end
        first_edge <= first_next;
        last_edge  <= last_next;
        edge_found <= found_next;
      end
    end
  end

endmodule

>>> rtl/lcps_fifo.sv
// Short register queue that carries row summaries from the front end to the back end.
// Depends on lcps_pkg only for the house import style.
`timescale 1ns / 1ps

module lcps_fifo #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty,
  output logic             full
);
  import lcps_pkg::*;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]  mem [DEPTH];
  logic [ADDR_W-1:0] wr_ptr;
  logic [ADDR_W-1:0] rd_ptr;
  logic [CNT_W-1:0]  count;

  assign empty   = (count == '0);
  assign full    = (count == CNT_W'(DEPTH));
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("row queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("row queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("row queue count out of range");

endmodule

>>> rtl/lcps_back.sv
// Steering back end: per row summary, updates the PI state and computes the command.
// Sequencer with one multiplier step per state and a digit-wise divide by 10000.
// Depends on lcps_pkg.
`timescale 1ns / 1ps

module lcps_back #(
  parameter int unsigned ROW_WIDTH = 500
) (
  input  logic               clk,
  input  logic               rst,
  input  lcps_pkg::cfg_t     cfg,
  input  logic               q_valid,
  input  lcps_pkg::row_sum_t q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output lcps_pkg::result_t  out_res
);
  import lcps_pkg::*;

  localparam logic signed [ERR_W-1:0] HALF = ERR_W'(ROW_WIDTH / 2);

  back_state_t state;
  back_state_t state_next;

  row_sum_t                   row;
  logic signed [ERR_W-1:0]    held_error;
  logic signed [INTEG_W-1:0]  error_integral;
  logic [7:0]                 lost_rows;
  logic                       seen_r;
  logic                       stop_r;
  logic signed [27:0]         step_prod;
  logic signed [21:0]         prop_prod;
  logic signed [NUM_W-1:0]    num;
  logic                       neg;
  logic [DIV_W-1:0]           quo;
  logic [REM_W-1:0]           rem;
  logic [DIG_W-1:0]           qd;
  logic [1:0]                 dig_cnt;
  logic [52:0]                scaled;
  logic [31:0]                rate;

  logic                       out_free;
  logic                       load;
  logic [POS_W-1:0]           span;
  logic [POS_W-1:0]           mid;
  logic signed [ERR_W-1:0]    err;
  logic [7:0]                 lost_inc;
  logic                       lost_stop;
  logic signed [27:0]         step_mul;
  logic signed [40:0]         acc_sum;
  logic signed [INTEG_W-1:0]  integ_sat;
  logic signed [21:0]         prop_mul;
  logic signed [29:0]         p100;
  logic [29:0]                lo_prod;
  logic signed [30:0]         hi_prod;
  logic [NUM_W-1:0]           num_abs;
  logic [PART_W-1:0]          div_part;
  logic [PART_W-4+RECIP_W-1:0] recip_prod;
  logic [PART_W:0]            qd_prod;
  logic                       div_last;
  logic [34:0]                sc_lo;
  logic [33:0]                sc_hi;
  logic [44:0]                shr;
  logic                       big_pos;
  logic                       big_neg;
  logic [31:0]                rate_next;

  // Row geometry and lost-row bookkeeping.
  assign span      = row.last_edge - row.first_edge;
  assign mid       = row.first_edge + {1'b0, span[POS_W-1:1]};
  assign err       = HALF - $signed({1'b0, mid});
  assign lost_inc  = (lost_rows != 8'hFF) ? lost_rows + 1'b1 : lost_rows;
  assign lost_stop = (lost_inc >= cfg.lost_limit);

  // Integral update with saturation to 40 bits.
  assign step_mul  = held_error * $signed({1'b0, cfg.time_step});
  assign acc_sum   = 41'(error_integral) + 41'(step_prod);
  assign integ_sat = (acc_sum[40] != acc_sum[39])
                   ? (acc_sum[40] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}})
                   : acc_sum[INTEG_W-1:0];

  // Numerator pieces: kp*err*100*65536 + ki*integral, the latter in two halves.
  assign prop_mul = held_error * $signed({1'b0, cfg.prop_gain_hundredths});
  assign p100     = prop_prod * $signed(PROP_SCALE);
  assign lo_prod  = cfg.integ_gain_ten_thousandths * error_integral[19:0];
  assign hi_prod  = $signed({1'b0, cfg.integ_gain_ten_thousandths})
                  * $signed(error_integral[INTEG_W-1:20]);

  // Magnitude divide, one 16-bit quotient digit per pass through ST_DQ and ST_DR.
  // The partial dividend is the running remainder with the next digit below it;
  // dividing it by 16 and then by 625 gives the same floor as dividing by 10000.
  assign num_abs    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign div_part   = {rem, quo[DIV_W-1 -: DIG_W]};
  assign recip_prod = div_part[PART_W-1:4] * RECIP_625;
  assign qd_prod    = qd * DIVISOR;
  assign div_last   = (dig_cnt == 2'(DIGITS - 1));

  // Angular scaling on the magnitude, then sign and saturation.
  assign sc_lo   = quo[SPLIT-1:0] * cfg.angular_scale;
  assign sc_hi   = quo[QUO_W-1:SPLIT] * cfg.angular_scale;
  assign shr     = scaled[52:8];
  assign big_pos = |shr[44:31];
  assign big_neg = (|shr[44:32]) || (shr[31] && (|shr[30:0]));

  always_comb begin
    if (neg) begin
      rate_next = big_neg ? 32'h8000_0000 : 32'd0 - shr[31:0];
    end else begin
      rate_next = big_pos ? 32'h7FFF_FFFF : shr[31:0];
    end
  end

  assign out_free = !out_valid || out_ready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (q_valid) state_next = ST_ERR;
      ST_ERR: begin
        if (row.seen) begin
          state_next = ST_INTEG;
        end else if (lost_stop) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_PROP;
        end
      end
      ST_INTEG:  state_next = ST_ACC;
      ST_ACC:    state_next = ST_PROP;
      ST_PROP:   state_next = ST_PSCALE;
      ST_PSCALE: state_next = ST_ILO;
      ST_ILO:    state_next = ST_IHI;
      ST_IHI:    state_next = ST_DIVSET;
      ST_DIVSET: state_next = ST_DQ;
      ST_DQ:     state_next = ST_DR;
      ST_DR:     state_next = div_last ? ST_SLO : ST_DQ;
      ST_SLO:    state_next = ST_SHI;
      ST_SHI:    state_next = ST_SAT;
      ST_SAT:    state_next = ST_OUT;
      ST_OUT:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    q_pop = 1'b0;
    load  = 1'b0;
    unique case (state)
      ST_IDLE: q_pop = q_valid;
      ST_OUT:  load  = out_free;
      default: begin
        q_pop = 1'b0;
        load  = 1'b0;
      end
    endcase
  end

  // Control state and loop state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      held_error     <= '0;
      error_integral <= '0;
      lost_rows      <= '0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_ERR) begin
        if (row.seen) begin
          held_error <= err;
          lost_rows  <= '0;
        end else begin
          lost_rows <= lost_inc;
        end
      end
      if (state == ST_ACC) begin
        error_integral <= integ_sat;
      end
    end
  end

  // Datapath working registers and the output register.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (q_pop) row <= q_data;
      end
      ST_ERR: begin
        seen_r <= row.seen;
        stop_r <= !row.seen && lost_stop;
      end
      ST_INTEG:  step_prod <= step_mul;
      ST_PROP:   prop_prod <= prop_mul;
      ST_PSCALE: num <= NUM_W'(p100) <<< 16;
      ST_ILO:    num <= num + $signed({{(NUM_W-30){1'b0}}, lo_prod});
      ST_IHI:    num <= num + (NUM_W'(hi_prod) <<< 20);
      ST_DIVSET: begin
        neg     <= num[NUM_W-1];
        quo     <= DIV_W'(num_abs);
        rem     <= '0;
        dig_cnt <= '0;
      end
      ST_DQ: qd <= recip_prod[RECIP_SHIFT +: DIG_W];
      ST_DR: begin
        rem     <= REM_W'({1'b0, div_part} - qd_prod);
        quo     <= {quo[DIV_W-DIG_W-1:0], qd};
        dig_cnt <= dig_cnt + 1'b1;
      end
      ST_SLO: scaled <= 53'(sc_lo);
      ST_SHI: scaled <= scaled + (53'(sc_hi) << SPLIT);
      ST_SAT: rate <= rate_next;
      ST_OUT: begin
        if (load) begin
          out_res.angular_rate <= stop_r ? 32'd0 : rate;
          out_res.forward_rate <= stop_r ? 16'd0 : cfg.cruise_speed;
          out_res.pixel_error  <= held_error[9:0];
          out_res.line_seen    <= seen_r;
          out_res.stopped      <= stop_r;
        end
      end
      default: begin
      end
    endcase
  end

  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.stopped) |->
      (out_res.angular_rate == 32'd0 && out_res.forward_rate == 16'd0))
    else $error("stop result carries a nonzero command");
  a_seen_not_stopped: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.line_seen) |-> !out_res.stopped)
    else $error("row with a line reported as stopped");
  a_quotient_fits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SLO) |-> (quo[DIV_W-1:QUO_W] == '0))
    else $error("bracket quotient exceeds its scaled width");
  a_digit_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DR) |-> (qd_prod <= {1'b0, div_part}))
    else $error("quotient digit too large for the partial dividend");

endmodule

>>> rtl/line_center_pi_steering_core.sv
// Top level of the line-center PI steering core: configuration registers,
// pixel front end, row queue and steering back end. Depends on lcps_pkg and
// lcps_front, lcps_fifo, lcps_back.
`timescale 1ns / 1ps

// Usage:
// Pixels of a scan row arrive on the s_ channel, one edge bit per transfer,
// with s_tlast on the last pixel of the row. Each row end produces exactly one
// steering command on the m_ channel; other pixels produce nothing.
// The front end takes one pixel per cycle while the queue is not full.
// Each row summary waits in a four-entry queue for the back end, which
// works through a row with a line in steps: error, integral, the multiply
// steps, the divide by 10000 in four 16-bit digits (each a reciprocal
// multiply and a remainder step), then the scaling and saturation. A row
// without a line skips the integral steps, and one that hits the stop goes
// straight to the output. Rows that take fewer pixel transfers than the back
// end spends on a row fill the queue, and s_tready drops until the back end
// catches up.
// When the receiver holds m_tready low, the command waits in the output
// register, the back end finishes its current row and then waits, and
// pixels keep flowing until the queue is full.
// Reset (synchronous, rst high) loads the register defaults and clears the
// row tracking, the integral, the held error and the lost-row count.
// Configuration writes are taken any cycle on cfg_we and should be made idle.

module line_center_pi_steering_core #(
  parameter int unsigned ROW_WIDTH = 500
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,  // [0] edge_bit, [7:1] zero
  input  logic                            s_tlast,  // row_end
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [63:0]                     m_tdata,  // [31:0] angular_rate, [47:32]
                                                    // forward_rate, [57:48] pixel_error,
                                                    // [63:58] zero
  output logic [1:0]                      m_tuser,  // [0] line_seen, [1] stopped
  input  logic                            cfg_we,
  input  logic [lcps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lcps_pkg::*;

  localparam int SUM_W = $bits(row_sum_t);

  cfg_t             cfg;
  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  row_sum_t         push_sum;
  logic [SUM_W-1:0] q_rd_data;
  result_t          res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain_hundredths       <= 10'd50;
      cfg.integ_gain_ten_thousandths <= 10'd50;
      cfg.time_step                  <= 16'd2185;
      cfg.angular_scale              <= 16'd256;
      cfg.lost_limit                 <= 8'd60;
      cfg.cruise_speed               <= 16'd9830;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KP:     cfg.prop_gain_hundredths       <= cfg_data[9:0];
        CFG_KI:     cfg.integ_gain_ten_thousandths <= cfg_data[9:0];
        CFG_DT:     cfg.time_step                  <= cfg_data;
        CFG_SCALE:  cfg.angular_scale              <= cfg_data;
        CFG_LIMIT:  cfg.lost_limit                 <= cfg_data[7:0];
        CFG_CRUISE: cfg.cruise_speed               <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lcps_front #(
    .ROW_WIDTH(ROW_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .edge_bit  (s_tdata[0]),
    .row_end   (s_tlast),
    .full      (q_full),
    .push      (q_push),
    .push_data (push_sum)
  );

  lcps_fifo #(
    .WIDTH(SUM_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (SUM_W'(push_sum)),
    .pop       (q_pop),
    .rd_data   (q_rd_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  lcps_back #(
    .ROW_WIDTH(ROW_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (!q_empty),
    .q_data    (row_sum_t'(q_rd_data)),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = {6'd0, res.pixel_error, res.forward_rate, res.angular_rate};
  assign m_tuser = {res.stopped, res.line_seen};

endmodule

>>> tb/line_center_pi_steering_core_test.sv
// Self-checking testbench for line_center_pi_steering_core: streams scan rows,
// predicts each steering command and checks it field by field.
// Depends on lcps_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module line_center_pi_steering_core_test;
  import lcps_pkg::*;

  localparam int ROW_WIDTH     = 500;
  localparam int SETTLE_CYCLES = 80;
  localparam int STALL_LIMIT   = 4000;
  localparam int LONG_HOLD     = 500;

  // kp is in hundredths: kp/100 in Q16.16 is kp * 65536 / 100, folded with the
  // common divide by 10000 applied to the whole bracket.
  localparam longint PROP_Q16   = 64'sd6553600;
  localparam longint BRACKET_DIV = 64'sd10000;
  localparam longint SCALE_DIV  = 64'sd256;
  localparam longint RATE_MAX   = 64'sd2147483647;
  localparam longint RATE_MIN   = -64'sd2147483648;
  localparam longint INTEG_MAX  = 64'sd549755813887;
  localparam longint INTEG_MIN  = -64'sd549755813888;

  typedef enum int {ROW_BLANK, ROW_SEGMENT, ROW_SPARSE, ROW_DENSE} row_kind_e;

  typedef struct {
    logic [31:0] angular_rate;
    logic [15:0] forward_rate;
    logic [9:0]  pixel_error;
    logic        line_seen;
    logic        stopped;
  } steer_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'd0;  // [0] edge_bit, [7:1] zero
  logic s_tlast = 1'b0;        // row_end
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;        // [31:0] angular_rate, [47:32] forward_rate, [57:48] pixel_error
  logic [1:0] m_tuser;         // [0] line_seen, [1] stopped
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predicted copy of the configuration and the steering state.
  logic [9:0]  kp_reg = 10'd50;
  logic [9:0]  ki_reg = 10'd50;
  logic [15:0] dt_reg = 16'd2185;
  logic [15:0] scale_reg = 16'd256;
  logic [7:0]  limit_reg = 8'd60;
  logic [15:0] cruise_reg = 16'd9830;
  logic [9:0]  pos_cnt = '0;
  logic [9:0]  first_pos = '0;
  logic [9:0]  last_pos = '0;
  logic        found = 1'b0;
  logic signed [10:0] held_err = '0;
  longint      integ = 0;
  logic [7:0]  lost_cnt = '0;

  steer_cmd_t pending_cmds[$];
  steer_cmd_t want;
  int fails = 0;
  int items_sent = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_left = 0;
  int hold_starts = 0;
  int hold_taken = 0;
  int stall_cycles = 0;

  line_center_pi_steering_core #(.ROW_WIDTH(ROW_WIDTH)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [31:0] steer_rate(input int err);
    longint num;
    longint bracket;
    longint rate;
    num = longint'(kp_reg) * longint'(err) * PROP_Q16 + longint'(ki_reg) * integ;
    bracket = num / BRACKET_DIV;
    rate = bracket * longint'(scale_reg) / SCALE_DIV;
    if (rate > RATE_MAX) rate = RATE_MAX;
    if (rate < RATE_MIN) rate = RATE_MIN;
    return rate[31:0];
  endfunction

  task automatic predict_pixel(input logic edge_bit, input logic row_end);
    steer_cmd_t cmd;
    int mid;
    int err;
    longint acc;
    if (edge_bit && pos_cnt < ROW_WIDTH) begin
      if (!found) first_pos = pos_cnt;
      last_pos = pos_cnt;
      found = 1'b1;
    end
    if (!row_end) begin
      if (pos_cnt != POS_MAX) pos_cnt = pos_cnt + 10'd1;
    end else begin
      cmd.line_seen = found;
      cmd.stopped = 1'b0;
      if (found) begin
        mid = int'(first_pos) + (int'(last_pos) - int'(first_pos)) / 2;
        err = ROW_WIDTH / 2 - mid;
        acc = integ + longint'(err) * longint'(dt_reg);
        if (acc > INTEG_MAX) acc = INTEG_MAX;
        if (acc < INTEG_MIN) acc = INTEG_MIN;
        integ = acc;
        held_err = err[10:0];
        lost_cnt = '0;
        cmd.angular_rate = steer_rate(err);
        cmd.forward_rate = cruise_reg;
      end else begin
        if (lost_cnt != 8'd255) lost_cnt = lost_cnt + 8'd1;
        if (lost_cnt >= limit_reg) begin
          cmd.stopped = 1'b1;
          cmd.angular_rate = '0;
          cmd.forward_rate = '0;
        end else begin
          cmd.angular_rate = steer_rate(int'(held_err));
          cmd.forward_rate = cruise_reg;
        end
      end
      cmd.pixel_error = held_err[9:0];
      pos_cnt = '0;
      first_pos = '0;
      last_pos = '0;
      found = 1'b0;
      pending_cmds = {pending_cmds, cmd};
    end
  endtask

  task automatic send_pixel(input logic edge_bit, input logic row_end);
    // Each cycle the sender idles with the chosen chance before offering the pixel.
    while ($urandom_range(99) < snd_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, edge_bit};
    s_tlast <= row_end;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    predict_pixel(edge_bit, row_end);
  endtask

  task automatic send_row(input int len, input row_kind_e kind, input int lo, input int hi);
    logic e;
    for (int i = 0; i < len; i++) begin
      case (kind)
        ROW_BLANK:   e = 1'b0;
        ROW_SEGMENT: e = (i >= lo) && (i <= hi);
        ROW_SPARSE:  e = ($urandom_range(9) == 0);
        default:     e = 1'($urandom_range(1));
      endcase
      send_pixel(e, i == len - 1);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_KP:     kp_reg = value[9:0];
      CFG_KI:     ki_reg = value[9:0];
      CFG_DT:     dt_reg = value[15:0];
      CFG_SCALE:  scale_reg = value[15:0];
      CFG_LIMIT:  limit_reg = value[7:0];
      CFG_CRUISE: cruise_reg = value[15:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input int kp, input int ki, input int dt, input int scale,
                              input int limit, input int cruise);
    write_reg(CFG_KP, kp);
    write_reg(CFG_KI, ki);
    write_reg(CFG_DT, dt);
    write_reg(CFG_SCALE, scale);
    write_reg(CFG_LIMIT, limit);
    write_reg(CFG_CRUISE, cruise);
  endtask

  function automatic int pick_value(input int hi);
    int r;
    r = $urandom_range(99);
    if (r < 15) return 0;
    if (r < 30) return hi;
    return $urandom_range(hi);
  endfunction

  task automatic randomize_config();
    int r;
    int limit;
    r = $urandom_range(99);
    if (r < 10) limit = 0;
    else if (r < 20) limit = 255;
    else limit = $urandom_range(8, 1);
    apply_config(pick_value(1023), pick_value(1023), pick_value(65535), pick_value(65535),
                 limit, pick_value(65535));
  endtask

  function automatic int row_length();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(8, 1);
    if (r < 90) return $urandom_range(40, 9);
    if (r < 98) return $urandom_range(150, 41);
    return $urandom_range(520, 250);
  endfunction

  // Drops valid, waits for every pending command, then lets the back end settle.
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed_rows();
    send_pixel(1'b0, 1'b1);  // nothing seen yet, so the error is zero
    send_pixel(1'b1, 1'b1);  // edge on the row end pixel
    send_pixel(1'b0, 1'b0);
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b0, 1'b0);
    send_pixel(1'b0, 1'b0);
    send_pixel(1'b1, 1'b1);
    send_row(3, ROW_BLANK, 0, 0);
    send_row(6, ROW_SEGMENT, 0, 5);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    apply_config(1023, 1023, 65535, 65535, 1, 65535);
    send_row(2, ROW_SEGMENT, 1, 1);
    send_row(1, ROW_BLANK, 0, 0);
    send_row(1, ROW_SEGMENT, 0, 0);
    wait_idle();
    apply_config(0, 0, 0, 0, 0, 0);
    send_row(2, ROW_SEGMENT, 0, 1);
    send_row(1, ROW_BLANK, 0, 0);
    wait_idle();
    apply_config(50, 50, 2185, 256, 60, 9830);
  endtask

  task automatic test_lost_saturation();
    apply_config(300, 500, 20000, 512, 255, 40000);
    send_row(4, ROW_SEGMENT, 1, 2);
    // The lost-row count reaches the limit and saturates.
    repeat (258) send_row(1, ROW_BLANK, 0, 0);
    send_row(3, ROW_DENSE, 0, 0);
    wait_idle();
  endtask

  task automatic test_long_rows();
    apply_config(1023, 1023, 65535, 65535, 8, 30000);
    // Edges beyond the row width are ignored and the position counter saturates.
    send_row(1030, ROW_SEGMENT, 470, 1029);
    send_row(20, ROW_SPARSE, 0, 0);
    wait_idle();
  endtask

  task automatic test_backpressure();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    @(posedge clk);
    hold_starts++;
    repeat (30) send_row($urandom_range(3, 1), row_kind_e'($urandom_range(3)), 0, 0);
    wait_idle();
  endtask

  task automatic test_random_rows(input int snd_pct, input int rcv_pct, input int budget);
    int start;
    int len;
    int lo;
    int r;
    bit reconfigured;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    reconfigured = 1'b0;
    randomize_config();
    start = items_sent;
    while (items_sent - start < budget) begin
      if (!reconfigured && items_sent - start >= budget / 2) begin
        wait_idle();
        randomize_config();
        reconfigured = 1'b1;
      end
      r = $urandom_range(99);
      len = row_length();
      if (r < 15) begin
        repeat ($urandom_range(10, 1)) send_row($urandom_range(4, 1), ROW_BLANK, 0, 0);
      end else if (r < 55) begin
        lo = $urandom_range(len - 1);
        send_row(len, ROW_SEGMENT, lo, $urandom_range(len - 1, lo));
      end else if (r < 80) begin
        send_row(len, ROW_SPARSE, 0, 0);
      end else begin
        send_row(len, ROW_DENSE, 0, 0);
      end
    end
    wait_idle();
  endtask

  // The receiver counts a long hold on its own once a test asks for one.
  always @(negedge clk) begin
    if (hold_taken != hold_starts) begin
      hold_taken <= hold_starts;
      hold_left <= LONG_HOLD - 1;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_cmds.size() == 0) begin
        $error("steering command transfer with no command pending");
        fails++;
      end else begin
        want = pending_cmds.pop_front();
        if (m_tdata[31:0] !== want.angular_rate) begin
          $error("angular_rate expected %0d got %0d", $signed(want.angular_rate),
                 $signed(m_tdata[31:0]));
          fails++;
        end
        if (m_tdata[47:32] !== want.forward_rate) begin
          $error("forward_rate expected %0d got %0d", want.forward_rate, m_tdata[47:32]);
          fails++;
        end
        if (m_tdata[57:48] !== want.pixel_error) begin
          $error("pixel_error expected %0d got %0d", $signed(want.pixel_error),
                 $signed(m_tdata[57:48]));
          fails++;
        end
        if (m_tuser[0] !== want.line_seen) begin
          $error("line_seen expected %0d got %0d", want.line_seen, m_tuser[0]);
          fails++;
        end
        if (m_tuser[1] !== want.stopped) begin
          $error("stopped expected %0d got %0d", want.stopped, m_tuser[1]);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    snd_idle_pct = 35;
    rcv_idle_pct = 56;
    test_directed_rows();
    test_register_extremes();
    test_lost_saturation();
    test_long_rows();
    test_backpressure();
    test_random_rows(35, 56, 30);
    test_random_rows(56, 35, 30);
    test_random_rows(0, 0, 30);
    wait_idle();
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
